### sv/assert_macros.svh
// assertion helpers used by rc4_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define RC4_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define RC4_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define RC4_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RC4_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### sv/rc4_pkg.sv
`timescale 1ns / 1ps

package rc4_pkg;

    // sizes
    localparam int BYTE_W    = 8;
    localparam int TBL_DEPTH = 256;
    localparam int ADDR_W    = $clog2(TBL_DEPTH);
    localparam int KEY_W     = 64;
    localparam int KEY_LEN   = 16;
    localparam int KIDX_W    = 4;
    localparam int CFG_IDX_W = 1;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [KIDX_W-1:0] t_kidx;
    typedef logic [KEY_W-1:0]  t_key;

    localparam t_addr ADDR_MAX     = t_addr'(TBL_DEPTH - 1);
    localparam t_kidx KIDX_LAST    = t_kidx'(KEY_LEN - 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_K_RD_N,
        S_K_RD_J,
        S_K_WR_N,
        S_K_WR_J,
        S_P_RD_I,
        S_P_RD_J,
        S_P_WR_I,
        S_P_WR_J,
        S_P_OUT
    } t_state;

    // request bundle toward the permutation memory
    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_byte wdata;
        t_addr raddr;
    } t_mem_req;

    // pick key byte k out of the two key words
    function automatic t_byte key_byte(t_key key_low, t_key key_high, t_kidx k);
        logic [2*KEY_W-1:0] key_all;
        key_all  = {key_high, key_low};
        key_byte = key_all[{k, 3'b000} +: BYTE_W];
    endfunction

endpackage

### sv/rc4_in_if.sv
`timescale 1ns / 1ps

interface rc4_in_if;
    logic                        valid;
    logic                        ready;
    logic [rc4_pkg::BYTE_W-1:0]  data_byte;
    logic                        first_byte;
    logic                        last_byte;

    modport source (output valid, output data_byte, output first_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                    output ready);
endinterface

### sv/rc4_out_if.sv
`timescale 1ns / 1ps

interface rc4_out_if;
    logic                        valid;
    logic                        ready;
    logic [rc4_pkg::BYTE_W-1:0]  out_byte;
    logic                        out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

### sv/rc4_perm_ram.sv
`timescale 1ns / 1ps

module rc4_perm_ram (
    input  logic              i_clk,
    input  rc4_pkg::t_mem_req i_req,
    output rc4_pkg::t_byte    o_rdata
);

    rc4_pkg::t_byte r_mem [rc4_pkg::TBL_DEPTH];
    rc4_pkg::t_byte r_rdata;

    // one write port, one registered read port (old data on collision)
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/rc4_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rc4_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rc4_pkg::t_key     i_key_low,
    input  rc4_pkg::t_key     i_key_high,
    rc4_in_if.sink            i_in,
    rc4_out_if.source         o_out,
    output rc4_pkg::t_mem_req o_mem_req,
    input  rc4_pkg::t_byte    i_mem_rdata
);

    rc4_pkg::t_state r_state, n_state;
    rc4_pkg::t_addr  r_n, n_n;
    rc4_pkg::t_kidx  r_kidx, n_kidx;
    rc4_pkg::t_byte  r_acc, n_acc;
    rc4_pkg::t_byte  r_i, n_i;
    rc4_pkg::t_byte  r_j, n_j;
    logic            r_keyed, n_keyed;
    rc4_pkg::t_byte  r_a, n_a;
    rc4_pkg::t_byte  r_b, n_b;
    rc4_pkg::t_byte  r_data, n_data;
    logic            r_last, n_last;
    logic            r_out_valid, n_out_valid;
    rc4_pkg::t_byte  r_out_byte, n_out_byte;
    logic            r_out_last, n_out_last;

    rc4_pkg::t_mem_req mem_req;
    logic              in_accept;
    rc4_pkg::t_byte    acc_sum;
    rc4_pkg::t_byte    j_sum;
    rc4_pkg::t_byte    t_sum;
    rc4_pkg::t_byte    ks;

    assign i_in.ready  = (r_state == rc4_pkg::S_IDLE);
    assign in_accept   = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.out_last = r_out_last;
    assign o_mem_req   = mem_req;

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rc4_pkg::S_IDLE;
            r_n         <= '0;
            r_kidx      <= '0;
            r_acc       <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_keyed     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_kidx      <= n_kidx;
            r_acc       <= n_acc;
            r_i         <= n_i;
            r_j         <= n_j;
            r_keyed     <= n_keyed;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_data     <= n_data;
        r_last     <= n_last;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    // sequencer: fill, key schedule, one keystream step per request
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_kidx      = r_kidx;
        n_acc       = r_acc;
        n_i         = r_i;
        n_j         = r_j;
        n_keyed     = r_keyed;
        n_a         = r_a;
        n_b         = r_b;
        n_data      = r_data;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        mem_req.we    = 1'b0;
        mem_req.waddr = r_n;
        mem_req.wdata = r_n;
        mem_req.raddr = rc4_pkg::t_addr'(r_i + 8'd1);

        acc_sum = rc4_pkg::t_byte'(r_acc + i_mem_rdata
                                   + rc4_pkg::key_byte(i_key_low, i_key_high, r_kidx));
        j_sum   = rc4_pkg::t_byte'(r_j + i_mem_rdata);
        t_sum   = rc4_pkg::t_byte'(r_a + r_b);
        // entry j was written in the same cycle as the read at t
        ks      = (t_sum == r_j) ? r_a : i_mem_rdata;

        // result taken downstream
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            rc4_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_data = i_in.data_byte;
                    n_last = i_in.last_byte;
                    if (i_in.first_byte || !r_keyed) begin
                        n_state = rc4_pkg::S_FILL;
                        n_n     = '0;
                    end else begin
                        n_state = rc4_pkg::S_P_RD_J;
                    end
                end
            end
            rc4_pkg::S_FILL: begin
                mem_req.we = 1'b1;
                n_n        = rc4_pkg::t_addr'(r_n + 8'd1);
                if (r_n == rc4_pkg::ADDR_MAX) begin
                    n_state = rc4_pkg::S_K_RD_N;
                    n_acc   = '0;
                    n_kidx  = '0;
                end
            end
            rc4_pkg::S_K_RD_N: begin
                mem_req.raddr = r_n;
                n_state       = rc4_pkg::S_K_RD_J;
            end
            rc4_pkg::S_K_RD_J: begin
                n_acc         = acc_sum;
                n_a           = i_mem_rdata;
                mem_req.raddr = acc_sum;
                n_state       = rc4_pkg::S_K_WR_N;
            end
            rc4_pkg::S_K_WR_N: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_n;
                mem_req.wdata = i_mem_rdata;
                n_state       = rc4_pkg::S_K_WR_J;
            end
            rc4_pkg::S_K_WR_J: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_acc;
                mem_req.wdata = r_a;
                n_n           = rc4_pkg::t_addr'(r_n + 8'd1);
                n_kidx        = (r_kidx == rc4_pkg::KIDX_LAST) ? '0
                                : rc4_pkg::t_kidx'(r_kidx + 4'd1);
                if (r_n == rc4_pkg::ADDR_MAX) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_keyed = 1'b1;
                    n_state = rc4_pkg::S_P_RD_I;
                end else begin
                    n_state = rc4_pkg::S_K_RD_N;
                end
            end
            rc4_pkg::S_P_RD_I: begin
                n_state = rc4_pkg::S_P_RD_J;
            end
            rc4_pkg::S_P_RD_J: begin
                n_i           = rc4_pkg::t_byte'(r_i + 8'd1);
                n_a           = i_mem_rdata;
                n_j           = j_sum;
                mem_req.raddr = j_sum;
                n_state       = rc4_pkg::S_P_WR_I;
            end
            rc4_pkg::S_P_WR_I: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_i;
                mem_req.wdata = i_mem_rdata;
                n_b           = i_mem_rdata;
                n_state       = rc4_pkg::S_P_WR_J;
            end
            rc4_pkg::S_P_WR_J: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_j;
                mem_req.wdata = r_a;
                mem_req.raddr = t_sum;
                n_state       = rc4_pkg::S_P_OUT;
            end
            rc4_pkg::S_P_OUT: begin
                // keep re-reading entry t while the output slot is busy
                mem_req.raddr = t_sum;
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_data ^ ks;
                    n_out_last  = r_last;
                    n_state     = rc4_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rc4_pkg::S_IDLE;
            end
        endcase
    end

    // checks
    `RC4_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, in_accept, r_state != rc4_pkg::S_IDLE)
    `RC4_ASSERT_NEXT(a_ksa_done_keyed, i_clk, i_rst_n, (r_state == rc4_pkg::S_K_WR_J) && (r_n == rc4_pkg::ADDR_MAX), r_keyed && (r_i == 8'd0) && (r_j == 8'd0))
    `RC4_ASSERT_IMPL(a_write_states, i_clk, i_rst_n, mem_req.we, (r_state == rc4_pkg::S_FILL) || (r_state == rc4_pkg::S_K_WR_N) || (r_state == rc4_pkg::S_K_WR_J) || (r_state == rc4_pkg::S_P_WR_I) || (r_state == rc4_pkg::S_P_WR_J))
    `RC4_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, (r_state == rc4_pkg::S_P_OUT) && r_out_valid && !o_out.ready, r_state == rc4_pkg::S_P_OUT)

endmodule

### sv/rc4_stream_cipher.sv
// a keyed byte steps through read j, write i, write j and out into the output register; a new
// byte is taken only in idle, after the last one is registered, paced by the dependent reads
// and two swap writes in the table; a message start (or first byte after reset) first fills
// the 256-entry table with the identity, then runs 256 key schedule steps and one index read
// reset (synchronous, active low) clears the key words, indices, keyed flag and output valid
`timescale 1ns / 1ps

module rc4_stream_cipher (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rc4_pkg::KEY_W-1:0]           i_cfg_data,
    rc4_in_if.sink                              i_in,
    rc4_out_if.source                           o_out
);

    rc4_pkg::t_key     r_key_low;
    rc4_pkg::t_key     r_key_high;
    rc4_pkg::t_mem_req mem_req;
    rc4_pkg::t_byte    mem_rdata;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rc4_pkg::REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                rc4_pkg::REG_KEY_HIGH: r_key_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer
    rc4_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key_low   (r_key_low),
        .i_key_high  (r_key_high),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    // permutation table
    rc4_perm_ram u_perm_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule
